[hw/rtl/fresnel_reflect_refract_assert.svh]
// ----------------------------------------------------------------------------
// fresnel_reflect_refract assertion macros
// Shared same-cycle and next-cycle implication checks for the shading pipe.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_REFLECT_REFRACT_ASSERT_SVH
`define FRESNEL_REFLECT_REFRACT_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define FRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fresnel_reflect_refract: check failed");

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define FRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fresnel_reflect_refract: check failed");

`endif

[hw/rtl/frr_pkg.sv]
// ----------------------------------------------------------------------------
// frr_pkg
// Widths, constants and the per-request context of the reflect/refract pipe.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int DIR_FRAC_BITS_DEF = 14;

    localparam int DIR_W   = 16;   // Q1.14 direction component
    localparam int IDX_W   = 14;   // Q2.12 refractive index
    localparam int REFL_W  = 17;   // Q1.16 reflectance, one inclusive
    localparam int DOT_W   = 34;   // exact N.I
    localparam int DN_W    = 50;   // dot times one normal component
    localparam int COS_W   = 31;   // Q.30 cosine, one inclusive
    localparam int SQIDX_W = 28;   // squared index
    localparam int COS2_W  = 62;   // squared cosine
    localparam int LHS_W   = 59;   // n1^2 * sin^2
    localparam int RAD_W   = 62;   // square root radicand
    localparam int PROD_W  = 45;   // index times cosine
    localparam int FR_W    = 46;   // Fresnel numerator / denominator
    localparam int MI_W    = 31;   // n1 times incident component
    localparam int MA_W    = 62;   // scaled normal term
    localparam int TNUM_W  = 34;   // refraction quotient numerator
    localparam int FD_W    = 64;   // Fresnel divider remainder
    localparam int RATIO_W = 19;   // Fresnel ratio, Q.18
    localparam int RS2_W   = 38;   // squared ratio
    localparam int Q30     = 30;
    localparam int RATIO_FRAC = 18;

    localparam int SD_STEPS = 31;  // quotient bits of sin^2 of the refracted ray
    localparam int SQ_STEPS = 31;  // root bits of the cosine
    localparam int FD_STEPS = 19;  // Fresnel ratio bits
    localparam int TD_STEPS = 17;  // refraction quotient bits before saturation

    localparam logic [REFL_W-1:0] REFL_ONE = 17'd65536;
    localparam logic [DIR_W-1:0]  DIR_MAX  = 16'h7FFF;
    localparam logic [DIR_W-1:0]  DIR_MIN  = 16'h8000;

    typedef struct packed {
        logic [2:0][DIR_W-1:0] nv;
        logic [2:0][DIR_W-1:0] iv;
        logic [2:0][DIR_W-1:0] rv;
        logic [IDX_W-1:0]      n1;
        logic [IDX_W-1:0]      n2;
        logic [COS_W-1:0]      cosi;
        logic                  dot_pos;
        logic                  tir;
    } frr_ctx_t;

    function automatic logic [DIR_W-1:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
        begin
            return DIR_MAX;
        end
        else if (v < -64'sd32768)
        begin
            return DIR_MIN;
        end
        else
        begin
            return v[DIR_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/fresnel_reflect_refract.sv]
// Throughput: one request per cycle unless stalled; every stage is a register
// stage and the divide and square-root units are unrolled one quotient/root
// bit per stage. A held result (out_valid with out_stall) freezes the whole
// pipe. Reset: rst_n clears every stage valid bit and the output valid;
// payload registers are not reset.
// ----------------------------------------------------------------------------
// fresnel_reflect_refract
// Mirror direction, Snell refraction and unpolarized Fresnel reflectance for
// one ray/surface hit per request, in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`include "fresnel_reflect_refract_assert.svh"

module fresnel_reflect_refract
    import frr_pkg::*;
#(
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DIR_W-1:0]  normal_x,
    input  logic signed [DIR_W-1:0]  normal_y,
    input  logic signed [DIR_W-1:0]  normal_z,
    input  logic signed [DIR_W-1:0]  incident_x,
    input  logic signed [DIR_W-1:0]  incident_y,
    input  logic signed [DIR_W-1:0]  incident_z,
    input  logic        [IDX_W-1:0]  index_from,
    input  logic        [IDX_W-1:0]  index_into,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DIR_W-1:0]  reflect_x,
    output logic signed [DIR_W-1:0]  reflect_y,
    output logic signed [DIR_W-1:0]  reflect_z,
    output logic signed [DIR_W-1:0]  refract_x,
    output logic signed [DIR_W-1:0]  refract_y,
    output logic signed [DIR_W-1:0]  refract_z,
    output logic        [REFL_W-1:0] reflectance,
    output logic                     total_internal
);

    // Rounding shifts that follow the direction format.
    localparam int RND_SH  = 2 * DIR_FRAC_BITS;
    localparam int COS_SHR = (RND_SH >= Q30) ? (RND_SH - Q30) : 0;
    localparam int COS_SHL = (RND_SH <  Q30) ? (Q30 - RND_SH) : 0;
    localparam logic [63:0] COS_HALF = (64'd1 << COS_SHR) >> 1;
    localparam logic [63:0] RND_HALF = (64'd1 << RND_SH) >> 1;
    localparam logic [63:0] Q30_ONE  = 64'd1 << Q30;

    // ------------------------------------------------------------------
    // Global advance: the pipe moves unless a finished result is held.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Reflected component: i - round(2*dot*n / 2^(2F)), half away from zero.
    function automatic logic [DIR_W-1:0] reflect_comp(input logic signed [DN_W-1:0] dn,
                                                      input logic signed [DIR_W-1:0] iv);
        logic signed [63:0] x;
        logic        [63:0] mag;
        logic        [63:0] q;
        logic signed [63:0] corr;
        logic signed [63:0] diff;
        x    = 64'(dn) <<< 1;
        mag  = x[63] ? 64'(-x) : 64'(x);
        q    = (mag + RND_HALF) >> RND_SH;
        corr = x[63] ? -$signed(q) : $signed(q);
        diff = 64'(iv) - corr;
        return sat16(diff);
    endfunction

    // ------------------------------------------------------------------
    // Front stages: dot product, cosine, reflection, sin^2 of incidence.
    // ------------------------------------------------------------------
    logic                      s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;
    frr_ctx_t                  s1_ctx_reg, s2_ctx_reg, s3_ctx_reg, s4_ctx_reg, s5_ctx_reg;
    frr_ctx_t                  s1_ctx_next, s3_ctx_next, s4_ctx_next;
    logic signed [31:0]        s1_prod_reg [3];
    logic signed [DOT_W-1:0]   s2_dot_reg;
    logic signed [DOT_W-1:0]   s2_dot_next;
    logic signed [DN_W-1:0]    s3_dn_reg [3];
    logic        [SQIDX_W-1:0] s3_n1sq_reg, s3_n2sq_reg;
    logic        [SQIDX_W-1:0] s4_n1sq_reg, s4_n2sq_reg;
    logic        [SQIDX_W-1:0] s5_n1sq_reg, s5_n2sq_reg;
    logic        [COS2_W-1:0]  s4_cos2_reg;
    logic        [COS_W-1:0]   s5_sin2i_reg;
    logic        [COS_W-1:0]   s5_sin2i_next;
    logic        [63:0]        s3_mag;
    logic        [63:0]        s3_cos_wide;
    logic        [62:0]        s5_sin_wide;

    always_comb
    begin
        s1_ctx_next    = '0;
        s1_ctx_next.nv = {normal_z, normal_y, normal_x};
        s1_ctx_next.iv = {incident_z, incident_y, incident_x};
        // Treat an index code of zero as the smallest nonzero code.
        s1_ctx_next.n1 = (index_from == '0) ? IDX_W'(1) : index_from;
        s1_ctx_next.n2 = (index_into == '0) ? IDX_W'(1) : index_into;
    end

    assign s2_dot_next = DOT_W'(s1_prod_reg[0]) + DOT_W'(s1_prod_reg[1])
                       + DOT_W'(s1_prod_reg[2]);

    always_comb
    begin
        s3_mag      = s2_dot_reg[DOT_W-1] ? 64'(-s2_dot_reg) : 64'(s2_dot_reg);
        s3_cos_wide = ((s3_mag + COS_HALF) >> COS_SHR) << COS_SHL;
        s3_ctx_next = s2_ctx_reg;
        // Clamp the cosine to one for vectors that are not unit length.
        s3_ctx_next.cosi    = (s3_cos_wide > Q30_ONE) ? COS_W'(Q30_ONE) : s3_cos_wide[COS_W-1:0];
        s3_ctx_next.dot_pos = !s2_dot_reg[DOT_W-1] && (s2_dot_reg != '0);
    end

    always_comb
    begin
        s4_ctx_next = s3_ctx_reg;
        for (int k = 0; k < 3; k++)
        begin
            s4_ctx_next.rv[k] = reflect_comp(s3_dn_reg[k], $signed(s3_ctx_reg.iv[k]));
        end
    end

    always_comb
    begin
        s5_sin_wide   = (63'(1) << 60) - 63'(s4_cos2_reg) + (63'(1) << 29);
        s5_sin2i_next = s5_sin_wide[60:30];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctx_reg <= s1_ctx_next;
            s1_prod_reg[0] <= normal_x * incident_x;
            s1_prod_reg[1] <= normal_y * incident_y;
            s1_prod_reg[2] <= normal_z * incident_z;
            s2_ctx_reg <= s1_ctx_reg;
            s2_dot_reg <= s2_dot_next;
            s3_ctx_reg <= s3_ctx_next;
            for (int k = 0; k < 3; k++)
            begin
                s3_dn_reg[k] <= s2_dot_reg * $signed(s2_ctx_reg.nv[k]);
            end
            s3_n1sq_reg <= s2_ctx_reg.n1 * s2_ctx_reg.n1;
            s3_n2sq_reg <= s2_ctx_reg.n2 * s2_ctx_reg.n2;
            s4_ctx_reg  <= s4_ctx_next;
            s4_cos2_reg <= s3_ctx_reg.cosi * s3_ctx_reg.cosi;
            s4_n1sq_reg <= s3_n1sq_reg;
            s4_n2sq_reg <= s3_n2sq_reg;
            s5_ctx_reg   <= s4_ctx_reg;
            s5_sin2i_reg <= s5_sin2i_next;
            s5_n1sq_reg  <= s4_n1sq_reg;
            s5_n2sq_reg  <= s4_n2sq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // sin^2 of the refracted ray: n1^2*sin2i / n2^2, one quotient bit per
    // stage. The first step also decides total internal reflection.
    // ------------------------------------------------------------------
    logic                      sd_v_reg   [SD_STEPS+1];
    frr_ctx_t                  sd_ctx_reg [SD_STEPS+1];
    logic        [LHS_W-1:0]   sd_rem_reg [SD_STEPS+1];
    logic        [COS_W-1:0]   sd_q_reg   [SD_STEPS+1];
    logic        [SQIDX_W-1:0] sd_d_reg   [SD_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_ctx_reg[0] <= s5_ctx_reg;
            sd_rem_reg[0] <= s5_n1sq_reg * s5_sin2i_reg;
            sd_q_reg[0]   <= '0;
            sd_d_reg[0]   <= s5_n2sq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sd_v_reg[0] <= s5_v_reg;
        end
    end

    for (genvar j = 1; j <= SD_STEPS; j++)
    begin : g_sd
        logic [LHS_W-1:0] dsh;
        logic             ge;
        frr_ctx_t         ctx_next;

        assign dsh = LHS_W'(sd_d_reg[j-1]) << (SD_STEPS - j);
        assign ge  = sd_rem_reg[j-1] >= dsh;

        always_comb
        begin
            ctx_next = sd_ctx_reg[j-1];
            if (j == 1)
            begin
                // Top step compares against n2^2 * one: beyond it, no refraction.
                ctx_next.tir = sd_rem_reg[j-1] > dsh;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sd_ctx_reg[j] <= ctx_next;
                sd_rem_reg[j] <= ge ? (sd_rem_reg[j-1] - dsh) : sd_rem_reg[j-1];
                sd_q_reg[j]   <= sd_q_reg[j-1] | (ge ? (COS_W'(1) << (SD_STEPS - j)) : '0);
                sd_d_reg[j]   <= sd_d_reg[j-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sd_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                sd_v_reg[j] <= sd_v_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // cosT = floor(sqrt((1 - sinT2) << 30)), one root bit per stage.
    // ------------------------------------------------------------------
    logic                    sq_v_reg   [SQ_STEPS+1];
    frr_ctx_t                sq_ctx_reg [SQ_STEPS+1];
    logic      [RAD_W-1:0]   sq_x_reg   [SQ_STEPS+1];
    logic      [RAD_W-1:0]   sq_res_reg [SQ_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_ctx_reg[0] <= sd_ctx_reg[SD_STEPS];
            sq_x_reg[0]   <= ((RAD_W'(1) << Q30) - RAD_W'(sd_q_reg[SD_STEPS])) << Q30;
            sq_res_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= sd_v_reg[SD_STEPS];
        end
    end

    for (genvar j = 1; j <= SQ_STEPS; j++)
    begin : g_sq
        logic [RAD_W-1:0] bitv;
        logic [RAD_W-1:0] trial;
        logic             ge;

        assign bitv  = RAD_W'(1) << (2 * (SQ_STEPS - j));
        assign trial = sq_res_reg[j-1] + bitv;
        assign ge    = sq_x_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_ctx_reg[j] <= sq_ctx_reg[j-1];
                sq_x_reg[j]   <= ge ? (sq_x_reg[j-1] - trial) : sq_x_reg[j-1];
                sq_res_reg[j] <= ge ? ((sq_res_reg[j-1] >> 1) + bitv) : (sq_res_reg[j-1] >> 1);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[j] <= sq_v_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Index-cosine products, Fresnel terms and refraction numerators.
    // ------------------------------------------------------------------
    logic                     p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    frr_ctx_t                 p1_ctx_reg, p2_ctx_reg, p3_ctx_reg, p4_ctx_reg, p5_ctx_reg;
    logic        [COS_W-1:0]  p1_cost;
    logic        [PROD_W-1:0] p1_c1_reg, p1_c2_reg, p1_c3_reg, p1_c4_reg;
    logic signed [FR_W-1:0]   p2_ps_num_reg, p2_pp_num_reg, p2_as_reg;
    logic        [FR_W-1:0]   p2_ps_den_reg, p2_pp_den_reg;
    logic signed [FR_W-1:0]   p2_ps_num_next, p2_pp_num_next, p2_as_next;
    logic signed [MI_W-1:0]   p3_mi_reg [3];
    logic signed [MA_W-1:0]   p3_ma_reg [3];
    logic signed [63:0]       p4_sum_reg [3];
    logic        [63:0]       p5_mag_reg [3];
    logic        [2:0]        p5_neg_reg;

    assign p1_cost = sq_res_reg[SQ_STEPS][COS_W-1:0];

    always_comb
    begin
        p2_ps_num_next = $signed({1'b0, p1_c1_reg}) - $signed({1'b0, p1_c2_reg});
        p2_pp_num_next = $signed({1'b0, p1_c3_reg}) - $signed({1'b0, p1_c4_reg});
        // Flip the normal when it faces along the ray so the refraction
        // continues through the surface.
        p2_as_next = p1_ctx_reg.dot_pos
                   ? ($signed({1'b0, p1_c2_reg}) - $signed({1'b0, p1_c1_reg}))
                   : p2_ps_num_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ctx_reg <= sq_ctx_reg[SQ_STEPS];
            p1_c1_reg  <= sq_ctx_reg[SQ_STEPS].n1 * sq_ctx_reg[SQ_STEPS].cosi;
            p1_c2_reg  <= sq_ctx_reg[SQ_STEPS].n2 * p1_cost;
            p1_c3_reg  <= sq_ctx_reg[SQ_STEPS].n2 * sq_ctx_reg[SQ_STEPS].cosi;
            p1_c4_reg  <= sq_ctx_reg[SQ_STEPS].n1 * p1_cost;
            p2_ctx_reg    <= p1_ctx_reg;
            p2_ps_num_reg <= p2_ps_num_next;
            p2_pp_num_reg <= p2_pp_num_next;
            p2_ps_den_reg <= {1'b0, p1_c1_reg} + {1'b0, p1_c2_reg};
            p2_pp_den_reg <= {1'b0, p1_c3_reg} + {1'b0, p1_c4_reg};
            p2_as_reg     <= p2_as_next;
            p3_ctx_reg <= p2_ctx_reg;
            for (int k = 0; k < 3; k++)
            begin
                p3_mi_reg[k] <= $signed({1'b0, p2_ctx_reg.n1}) * $signed(p2_ctx_reg.iv[k]);
                p3_ma_reg[k] <= p2_as_reg * $signed(p2_ctx_reg.nv[k]);
            end
            p4_ctx_reg <= p3_ctx_reg;
            for (int k = 0; k < 3; k++)
            begin
                p4_sum_reg[k] <= (64'(p3_mi_reg[k]) <<< Q30) + 64'(p3_ma_reg[k]);
            end
            p5_ctx_reg <= p4_ctx_reg;
            for (int k = 0; k < 3; k++)
            begin
                p5_mag_reg[k] <= p4_sum_reg[k][63] ? 64'(-p4_sum_reg[k]) : 64'(p4_sum_reg[k]);
                p5_neg_reg[k] <= p4_sum_reg[k][63];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg <= sq_v_reg[SQ_STEPS];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Fresnel ratios |num|*2^18/den for s and p, one bit per stage. Runs
    // beside the main path; it has no valid bits of its own.
    // ------------------------------------------------------------------
    logic [1:0][FD_W-1:0]    fd_rem_reg  [FD_STEPS+1];
    logic [1:0][FR_W-1:0]    fd_d_reg    [FD_STEPS+1];
    logic [1:0][RATIO_W-1:0] fd_q_reg    [FD_STEPS+1];
    logic [1:0]              fd_zero_reg [FD_STEPS+1];
    logic [FR_W-1:0]         fd_ps_mag, fd_pp_mag;

    assign fd_ps_mag = p2_ps_num_reg[FR_W-1] ? FR_W'(-p2_ps_num_reg) : FR_W'(p2_ps_num_reg);
    assign fd_pp_mag = p2_pp_num_reg[FR_W-1] ? FR_W'(-p2_pp_num_reg) : FR_W'(p2_pp_num_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fd_rem_reg[0][0]  <= FD_W'(fd_ps_mag) << RATIO_FRAC;
            fd_rem_reg[0][1]  <= FD_W'(fd_pp_mag) << RATIO_FRAC;
            fd_d_reg[0][0]    <= p2_ps_den_reg;
            fd_d_reg[0][1]    <= p2_pp_den_reg;
            fd_q_reg[0]       <= '0;
            fd_zero_reg[0][0] <= (p2_ps_den_reg == '0);
            fd_zero_reg[0][1] <= (p2_pp_den_reg == '0);
        end
    end

    for (genvar j = 1; j <= FD_STEPS; j++)
    begin : g_fd
        logic [1:0][FD_W-1:0]    rem_next;
        logic [1:0][RATIO_W-1:0] q_next;

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (fd_rem_reg[j-1][l] >= (FD_W'(fd_d_reg[j-1][l]) << (FD_STEPS - j)))
                begin
                    rem_next[l] = fd_rem_reg[j-1][l] - (FD_W'(fd_d_reg[j-1][l]) << (FD_STEPS - j));
                    q_next[l]   = fd_q_reg[j-1][l] | (RATIO_W'(1) << (FD_STEPS - j));
                end
                else
                begin
                    rem_next[l] = fd_rem_reg[j-1][l];
                    q_next[l]   = fd_q_reg[j-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fd_rem_reg[j]  <= rem_next;
                fd_q_reg[j]    <= q_next;
                fd_d_reg[j]    <= fd_d_reg[j-1];
                fd_zero_reg[j] <= fd_zero_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Refraction quotients round(sum / (n2*2^30)), one bit per stage.
    // A numerator at or above n2*2^17 saturates regardless of the bits.
    // ------------------------------------------------------------------
    logic                       td_v_reg   [TD_STEPS+1];
    frr_ctx_t                   td_ctx_reg [TD_STEPS+1];
    logic [2:0][TNUM_W-1:0]     td_num_reg [TD_STEPS+1];
    logic [2:0][TD_STEPS-1:0]   td_q_reg   [TD_STEPS+1];
    logic [2:0]                 td_neg_reg [TD_STEPS+1];
    logic [2:0]                 td_ovf_reg [TD_STEPS+1];
    logic [2:0][TNUM_W-1:0]     td_num0_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            td_num0_next[k] = TNUM_W'((p5_mag_reg[k] + (64'(p5_ctx_reg.n2) << (Q30 - 1))) >> Q30);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            td_ctx_reg[0] <= p5_ctx_reg;
            td_num_reg[0] <= td_num0_next;
            td_q_reg[0]   <= '0;
            td_neg_reg[0] <= p5_neg_reg;
            td_ovf_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            td_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            td_v_reg[0] <= p5_v_reg;
        end
    end

    for (genvar j = 1; j <= TD_STEPS; j++)
    begin : g_td
        logic [TNUM_W-1:0]        dsh;
        logic [2:0][TNUM_W-1:0]   num_next;
        logic [2:0][TD_STEPS-1:0] q_next;
        logic [2:0]               ovf_next;

        assign dsh = TNUM_W'(td_ctx_reg[j-1].n2) << (TD_STEPS - j);

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (td_num_reg[j-1][k] >= dsh)
                begin
                    num_next[k] = td_num_reg[j-1][k] - dsh;
                    q_next[k]   = td_q_reg[j-1][k] | (TD_STEPS'(1) << (TD_STEPS - j));
                end
                else
                begin
                    num_next[k] = td_num_reg[j-1][k];
                    q_next[k]   = td_q_reg[j-1][k];
                end
                if (j == 1)
                begin
                    ovf_next[k] = td_num_reg[j-1][k] >= (dsh << 1);
                end
                else
                begin
                    ovf_next[k] = td_ovf_reg[j-1][k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                td_ctx_reg[j] <= td_ctx_reg[j-1];
                td_num_reg[j] <= num_next;
                td_q_reg[j]   <= q_next;
                td_neg_reg[j] <= td_neg_reg[j-1];
                td_ovf_reg[j] <= ovf_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                td_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                td_v_reg[j] <= td_v_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Squared ratios, aligned with the last refraction step.
    // ------------------------------------------------------------------
    logic [1:0][RS2_W-1:0]   fr_rs2_reg;
    logic [1:0][RATIO_W-1:0] fr_ratio;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            // A zero denominator (grazing on both sides) counts as ratio one.
            fr_ratio[l] = fd_zero_reg[FD_STEPS][l] ? (RATIO_W'(1) << RATIO_FRAC)
                                                   : fd_q_reg[FD_STEPS][l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                fr_rs2_reg[l] <= fr_ratio[l] * fr_ratio[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate refraction, round reflectance, apply TIR.
    // ------------------------------------------------------------------
    logic [2:0][DIR_W-1:0] out_r_reg, out_t_reg;
    logic [REFL_W-1:0]     out_refl_reg;
    logic                  out_tir_reg;
    logic [2:0][DIR_W-1:0] out_t_next;
    logic [REFL_W-1:0]     out_refl_next;
    logic [RS2_W:0]        out_rsum;
    logic [RS2_W-21:0]     out_rround;
    frr_ctx_t              out_ctx;

    assign out_ctx = td_ctx_reg[TD_STEPS];

    always_comb
    begin
        out_rsum   = (RS2_W+1)'(fr_rs2_reg[0]) + (RS2_W+1)'(fr_rs2_reg[1])
                   + ((RS2_W+1)'(1) << 20);
        out_rround = out_rsum[RS2_W:21];
        if (out_ctx.tir)
        begin
            out_refl_next = REFL_ONE;
        end
        else if ((RS2_W-20)'(out_rround) > (RS2_W-20)'(REFL_ONE))
        begin
            out_refl_next = REFL_ONE;
        end
        else
        begin
            out_refl_next = REFL_W'(out_rround);
        end

        for (int k = 0; k < 3; k++)
        begin
            if (out_ctx.tir)
            begin
                out_t_next[k] = '0;
            end
            else if (td_neg_reg[TD_STEPS][k])
            begin
                if (td_ovf_reg[TD_STEPS][k] || (td_q_reg[TD_STEPS][k] > 17'd32768))
                begin
                    out_t_next[k] = DIR_MIN;
                end
                else
                begin
                    out_t_next[k] = DIR_W'(17'd0 - td_q_reg[TD_STEPS][k]);
                end
            end
            else
            begin
                if (td_ovf_reg[TD_STEPS][k] || (td_q_reg[TD_STEPS][k] > 17'd32767))
                begin
                    out_t_next[k] = DIR_MAX;
                end
                else
                begin
                    out_t_next[k] = td_q_reg[TD_STEPS][k][DIR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_r_reg    <= out_ctx.rv;
            out_t_reg    <= out_t_next;
            out_refl_reg <= out_refl_next;
            out_tir_reg  <= out_ctx.tir;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= td_v_reg[TD_STEPS];
        end
    end

    assign out_valid      = out_valid_reg;
    assign reflect_x      = out_r_reg[0];
    assign reflect_y      = out_r_reg[1];
    assign reflect_z      = out_r_reg[2];
    assign refract_x      = out_t_reg[0];
    assign refract_y      = out_t_reg[1];
    assign refract_z      = out_t_reg[2];
    assign reflectance    = out_refl_reg;
    assign total_internal = out_tir_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FRR_ASSERT_NOW(a_tir_result, out_valid_reg && out_tir_reg, (out_refl_reg == REFL_ONE) && (out_t_reg == '0))
    `FRR_ASSERT_NOW(a_open_when_empty, !out_valid_reg, !in_stall)
    `FRR_ASSERT_NEXT(a_last_to_out, td_v_reg[TD_STEPS] && !in_stall, out_valid_reg)

endmodule
